// ===== rtl/core/mpp_pkg.sv =====
// Shared types and constants for the palindrome-prefix counter.
// Used by the controller, the datapath and the top level; no dependencies.
package mpp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CNT_W  = 8;
  localparam logic [CNT_W-1:0] OUT_MAX = 8'hFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // store one accepted word
    logic init_p;  // candidate prefix length takes the fill count
    logic setup;   // point the two cursors at the ends of the candidate
    logic step;    // move both cursors inward
    logic shrink;  // drop one byte from the candidate prefix
    logic emit;    // register the result and clear the string
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic p_le1;       // candidate prefix is one byte or less
    logic mismatch;    // bytes under the two cursors differ
    logic more_pairs;  // cursors still apart after the next step
  } stat_t;

endpackage

// ===== rtl/core/mpp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mpp_datapath.sv =====
// Datapath: string store, fill count, cursors, candidate length and result.
// Depends on mpp_pkg and mpp_ram.
module mpp_datapath #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mpp_pkg::cmd_t               cmd,
  output mpp_pkg::stat_t              stat,
  input  logic [mpp_pkg::CHAR_W-1:0]  char_in,
  output logic                        done,
  output logic [mpp_pkg::CNT_W-1:0]   chars_needed,
  output logic                        overflow
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] fill;
  logic          ovf;
  logic [CW-1:0] p;
  logic [AW-1:0] a;
  logic [AW-1:0] b;
  logic          full;
  logic          we;
  logic [mpp_pkg::CHAR_W-1:0] rd_a;
  logic [mpp_pkg::CHAR_W-1:0] rd_b;
  logic [CW-1:0]   need;
  logic [CW+7:0]   need_ext;
  logic [mpp_pkg::CNT_W-1:0] need_sat;

  assign full = (fill == CW'(MAX_LEN));
  assign we   = cmd.load && !full;

  // Two copies of the store, one per cursor
  mpp_ram #(.WIDTH(mpp_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (fill[AW-1:0]),
    .wdata (char_in),
    .raddr (a),
    .rdata (rd_a)
  );

  mpp_ram #(.WIDTH(mpp_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (fill[AW-1:0]),
    .wdata (char_in),
    .raddr (b),
    .rdata (rd_b)
  );

  // Status toward the controller
  assign stat.p_le1      = (p <= CW'(1));
  assign stat.mismatch   = (rd_a != rd_b);
  assign stat.more_pairs = (({1'b0, a} + (AW+1)'(2)) < {1'b0, b});

  // Saturate the count to the output width
  assign need     = fill - p;
  assign need_ext = {8'd0, need};
  assign need_sat = (need_ext > (CW+8)'(mpp_pkg::OUT_MAX)) ? mpp_pkg::OUT_MAX
                                                          : need_ext[7:0];

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ovf  <= 1'b0;
    end else if (cmd.emit) begin
      fill <= '0;
      ovf  <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        fill <= fill + CW'(1);
      end
    end
  end

  // Candidate length and cursors
  always_ff @(posedge clk) begin
    if (cmd.init_p) begin
      p <= fill;
    end else if (cmd.shrink) begin
      p <= p - CW'(1);
    end
    if (cmd.setup) begin
      a <= '0;
      b <= AW'(p - CW'(1));
    end else if (cmd.step) begin
      a <= a + AW'(1);
      b <= b - AW'(1);
    end
  end

  // Result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      chars_needed <= need_sat;
      overflow     <= ovf;
    end
  end

endmodule

// ===== rtl/core/mpp_ctrl.sv =====
// Controller state machine: load, then search palindromic prefixes longest first.
// Depends on mpp_pkg.
module mpp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           is_last,
  input  mpp_pkg::stat_t stat,
  output mpp_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (is_last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init_p = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        if (stat.p_le1) begin
          state_next = S_DONE;
        end else begin
          cmd.setup  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.mismatch) begin
          cmd.shrink = 1'b1;
          state_next = S_SETUP;
        end else if (stat.more_pairs) begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_READ)
    else $error("compare without a preceding read");

  a_last_starts_search: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> state == S_INIT)
    else $error("last word did not start the search");

  a_plain_word_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !is_last |=> state == S_IDLE)
    else $error("non-final word left idle");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_IDLE)
    else $error("result state did not return to idle");

endmodule

// ===== rtl/core/min_prepend_for_palindrome.sv =====
// Top level of the palindrome-prefix counter.
// Depends on mpp_pkg, mpp_ctrl, mpp_datapath (and mpp_ram through it).
//
// Usage: present one string byte per word on char_in with is_last, and raise
// start. A word is taken at a rising edge with start high and busy low.
// Words that are not last leave busy low. On the last word busy rises and
// the block searches the stored string for its longest palindromic prefix,
// trying lengths from the full length downward; each new candidate length
// passes a setup state that sets the cursors, and each byte-pair comparison
// passes a read state (registered RAM read) and then a compare state.
// When the result appears, busy is already low again. The result
// (chars_needed, overflow) is shown for exactly one cycle with done high;
// the receiver cannot stall it. Bytes past MAX_LEN are dropped and flagged
// in overflow. chars_needed saturates at 255. A synchronous rst empties the
// string, clears the flag and returns to idle; store contents are not
// cleared and are only read after being written.
module min_prepend_for_palindrome #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mpp_pkg::CHAR_W-1:0]  char_in,
  input  logic                        is_last,
  output logic                        done,
  output logic [mpp_pkg::CNT_W-1:0]   chars_needed,
  output logic                        overflow
);

  mpp_pkg::cmd_t  cmd;
  mpp_pkg::stat_t stat;

  mpp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_last (is_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  mpp_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .char_in      (char_in),
    .done         (done),
    .chars_needed (chars_needed),
    .overflow     (overflow)
  );

endmodule
